// ===== rtl/core/rsb_pkg.sv =====
`default_nettype none
package rsb_pkg;

    localparam int PIX_W  = 16;
    localparam int CH_W   = 5;
    localparam int WT_W   = 5;
    localparam int SH_W   = 4;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 8;
    localparam int FULL_W = 6;   // width of 32 - a

    // pixel_mode codes
    localparam logic [1:0] MODE_555 = 2'd0;
    localparam logic [1:0] MODE_565 = 2'd1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SHADE   = 3'd1;
    localparam logic [IDX_W-1:0] REG_R_SHIFT = 3'd2;
    localparam logic [IDX_W-1:0] REG_G_SHIFT = 3'd3;
    localparam logic [IDX_W-1:0] REG_B_SHIFT = 3'd4;

    localparam logic [SH_W-1:0] R_SHIFT_RST = 4'd10;
    localparam logic [SH_W-1:0] G_SHIFT_RST = 4'd5;
    localparam logic [SH_W-1:0] B_SHIFT_RST = 4'd0;

    typedef struct packed {
        logic [CH_W-1:0] s_r;
        logic [CH_W-1:0] d_r;
        logic [CH_W-1:0] s_g;
        logic [CH_W-1:0] d_g;
        logic [CH_W-1:0] s_b;
        logic [CH_W-1:0] d_b;
        logic [WT_W-1:0] wt;
        logic            ok;
    } t_chan_set;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic            ok;
    } t_sums;

    typedef struct packed {
        logic [SH_W-1:0] r;
        logic [SH_W-1:0] g;
        logic [SH_W-1:0] b;
    } t_place_cfg;

endpackage
`default_nettype wire

// ===== rtl/core/rgb16_shade_blend_core.sv =====
// Blends a 16-bit source pixel with a 16-bit destination pixel per word.
// Input stream: s_axis_* carries one pixel pair per word, source in the low
// half. Output stream: m_axis_* carries the blended pixel in tdata and a
// written flag in tuser (0 when the pixel format is unsupported; tdata is
// then 0).
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high: 0 pixel mode, 1 shade level, 2..4 red/green/blue output shifts.
// Registers should only change while no word is in flight.
// Each word passes through four register stages: channel unpack,
// weight multiply, channel add, pack.
// Throughput is one word per cycle while m_axis_tready is high; each stage
// holds one word and loads whenever it is empty or its downstream stage
// moves, so words keep entering while a result waits in the output register.
// When m_axis_tready is low, words pile up in the empty stages; s_axis_tready
// drops only once all four stages are full. Nothing is lost or repeated.
// Synchronous active-low reset empties the pipe and restores register
// defaults (555 mode, shade 0, shifts 10/5/0).
`default_nettype none
module rgb16_shade_blend_core
    import rsb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [2*PIX_W-1:0] s_axis_tdata,  // [15:0] src_pixel, [31:16] dst_pixel
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [PIX_W-1:0]       m_axis_tdata,  // [15:0] out_pixel
    output logic                   m_axis_tuser   // [0] written
);

    logic [1:0]      r_mode;
    logic [CFG_W-1:0] r_shade;
    t_place_cfg      r_place;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_555;
            r_shade   <= '0;
            r_place.r <= R_SHIFT_RST;
            r_place.g <= G_SHIFT_RST;
            r_place.b <= B_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:    r_mode    <= i_cfg_data[1:0];
                REG_SHADE:   r_shade   <= i_cfg_data;
                REG_R_SHIFT: r_place.r <= i_cfg_data[SH_W-1:0];
                REG_G_SHIFT: r_place.g <= i_cfg_data[SH_W-1:0];
                REG_B_SHIFT: r_place.b <= i_cfg_data[SH_W-1:0];
                default: ;
            endcase
        end
    end

    logic      w_up_valid, w_up_ready;
    t_chan_set w_chan;
    logic      w_mix_valid, w_mix_ready;
    t_sums     w_sums;

    rsb_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_src   (s_axis_tdata[PIX_W-1:0]),
        .i_dst   (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_mode  (r_mode),
        .i_wt    (r_shade[CFG_W-1:3]),
        .o_valid (w_up_valid),
        .i_ready (w_up_ready),
        .o_chan  (w_chan)
    );

    rsb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_up_valid),
        .o_ready (w_up_ready),
        .i_chan  (w_chan),
        .o_valid (w_mix_valid),
        .i_ready (w_mix_ready),
        .o_sums  (w_sums)
    );

    rsb_pack u_pack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_mix_valid),
        .o_ready   (w_mix_ready),
        .i_sums    (w_sums),
        .i_place   (r_place),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pixel   (m_axis_tdata),
        .o_written (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rsb_unpack.sv =====
`default_nettype none
module rsb_unpack
    import rsb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [PIX_W-1:0] i_src,
    input  wire logic [PIX_W-1:0] i_dst,
    input  wire logic [1:0]       i_mode,
    input  wire logic [WT_W-1:0]  i_wt,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_chan_set             o_chan
);

    logic      r_v;
    t_chan_set r_chan;
    t_chan_set n_chan;

    always_comb begin
        n_chan     = '0;
        n_chan.wt  = i_wt;
        n_chan.s_b = i_src[4:0];
        n_chan.d_b = i_dst[4:0];
        case (i_mode)
            MODE_555: begin
                n_chan.s_r = i_src[14:10];
                n_chan.d_r = i_dst[14:10];
                n_chan.s_g = i_src[9:5];
                n_chan.d_g = i_dst[9:5];
                n_chan.ok  = 1'b1;
            end
            MODE_565: begin
                n_chan.s_r = i_src[15:11];
                n_chan.d_r = i_dst[15:11];
                n_chan.s_g = i_src[10:6];
                n_chan.d_g = i_dst[10:6];
                n_chan.ok  = 1'b1;
            end
            default: begin
                n_chan.ok = 1'b0;
            end
        endcase
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_chan <= n_chan;
        end
    end

    assign o_valid = r_v;
    assign o_chan  = r_chan;

endmodule
`default_nettype wire

// ===== rtl/core/rsb_mix.sv =====
`default_nettype none
module rsb_mix
    import rsb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_chan_set i_chan,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_sums          o_sums
);

    // first stage: weighted terms, each already divided by 32
    typedef struct packed {
        logic [CH_W-1:0] s_r;
        logic [CH_W-1:0] d_r;
        logic [CH_W-1:0] s_g;
        logic [CH_W-1:0] d_g;
        logic [CH_W-1:0] s_b;
        logic [CH_W-1:0] d_b;
        logic            ok;
    } t_terms;

    logic   r_v_t;
    logic   r_v_s;
    t_terms r_terms;
    t_terms n_terms;
    t_sums  r_sums;
    t_sums  n_sums;
    logic   w_ready_s;
    logic   w_ready_t;

    logic [FULL_W-1:0]      w_inv;
    logic [CH_W+FULL_W-1:0] w_ps_r, w_ps_g, w_ps_b;
    logic [2*CH_W-1:0]      w_pd_r, w_pd_g, w_pd_b;

    assign w_inv  = FULL_W'(32) - FULL_W'(i_chan.wt);
    assign w_ps_r = (CH_W+FULL_W)'(i_chan.s_r) * (CH_W+FULL_W)'(w_inv);
    assign w_ps_g = (CH_W+FULL_W)'(i_chan.s_g) * (CH_W+FULL_W)'(w_inv);
    assign w_ps_b = (CH_W+FULL_W)'(i_chan.s_b) * (CH_W+FULL_W)'(w_inv);
    assign w_pd_r = (2*CH_W)'(i_chan.d_r) * (2*CH_W)'(i_chan.wt);
    assign w_pd_g = (2*CH_W)'(i_chan.d_g) * (2*CH_W)'(i_chan.wt);
    assign w_pd_b = (2*CH_W)'(i_chan.d_b) * (2*CH_W)'(i_chan.wt);

    always_comb begin
        n_terms.s_r = w_ps_r[CH_W+4:5];
        n_terms.s_g = w_ps_g[CH_W+4:5];
        n_terms.s_b = w_ps_b[CH_W+4:5];
        n_terms.d_r = w_pd_r[2*CH_W-1:5];
        n_terms.d_g = w_pd_g[2*CH_W-1:5];
        n_terms.d_b = w_pd_b[2*CH_W-1:5];
        n_terms.ok  = i_chan.ok;
    end

    // weights add to 32, so each sum stays within 5 bits
    always_comb begin
        n_sums.r  = r_terms.s_r + r_terms.d_r;
        n_sums.g  = r_terms.s_g + r_terms.d_g;
        n_sums.b  = r_terms.s_b + r_terms.d_b;
        n_sums.ok = r_terms.ok;
    end

    assign w_ready_s = !r_v_s || i_ready;
    assign w_ready_t = !r_v_t || w_ready_s;
    assign o_ready   = w_ready_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_t <= 1'b0;
            r_v_s <= 1'b0;
        end else begin
            if (w_ready_t) begin
                r_v_t <= i_valid;
            end
            if (w_ready_s) begin
                r_v_s <= r_v_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_t && i_valid) begin
            r_terms <= n_terms;
        end
        if (w_ready_s && r_v_t) begin
            r_sums <= n_sums;
        end
    end

    assign o_valid = r_v_s;
    assign o_sums  = r_sums;

endmodule
`default_nettype wire

// ===== rtl/core/rsb_pack.sv =====
`default_nettype none
module rsb_pack
    import rsb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_sums            i_sums,
    input  wire t_place_cfg       i_place,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PIX_W-1:0]      o_pixel,
    output logic                  o_written
);

    logic             r_v;
    logic [PIX_W-1:0] r_pixel;
    logic             r_written;
    logic [PIX_W-1:0] n_pixel;
    logic [PIX_W-1:0] w_r, w_g, w_b;

    // bits pushed past the top are dropped
    assign w_r = PIX_W'(i_sums.r) << i_place.r;
    assign w_g = PIX_W'(i_sums.g) << i_place.g;
    assign w_b = PIX_W'(i_sums.b) << i_place.b;
    assign n_pixel = i_sums.ok ? (w_r | w_g | w_b) : '0;

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel   <= n_pixel;
            r_written <= i_sums.ok;
        end
    end

    assign o_valid   = r_v;
    assign o_pixel   = r_pixel;
    assign o_written = r_written;

endmodule
`default_nettype wire

// ===== rtl/core/rsb_checker.sv =====
`default_nettype none
module rsb_checker
    import rsb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tready,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [PIX_W-1:0] m_axis_tdata,
    input  wire logic             m_axis_tuser
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed under stall");

    // unwritten pixels come out as zero
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("unwritten pixel is not zero");

    // an empty output register means the pipe has room
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind rgb16_shade_blend_core rsb_checker u_rsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
